// File: design/rcn_pkg.sv
// Package for the RGB chromaticity normaliser: field widths, pipeline depth
// and the control struct passed between the pipeline control and the lanes.
// No dependencies.
package rcn_pkg;

  localparam int unsigned LANES      = 3;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned SCALE      = (1 << CH_W) - 1;
  // Numerator 2*SCALE*c + sum and denominator 2*sum.
  localparam int unsigned NUM_W      = 17;
  localparam int unsigned DEN_W      = SUM_W + 1;
  // One quotient bit is resolved per divider stage.
  localparam int unsigned DIV_STEPS  = CH_W;
  localparam int unsigned TRIAL_W    = DEN_W + DIV_STEPS - 1;
  // Input register, numerator stage and the divider stages.
  localparam int unsigned PIPE_DEPTH = DIV_STEPS + 2;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
    logic                  out_en;
    logic                  out_dark;
  } pipe_ctl_t;

endpackage

// File: design/rcn_front.sv
// Input stage: dark threshold register, channel sum and the dark compare,
// and the stage-0 payload registers. Depends on rcn_pkg.
module rcn_front import rcn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [SUM_W-1:0] cfg_data_i,
  input  chan_t            chan_i [LANES],
  input  logic             load_i,
  output chan_t            chan_o [LANES],
  output sum_t             sum_o,
  output logic             dark_o
);

  sum_t  thr_q;
  sum_t  sum_d;
  sum_t  sum_q;
  chan_t chan_q [LANES];

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_d = sum_d + SUM_W'(chan_i[l]);
    end
  end

  // A pixel is dark unless its sum is strictly above the threshold.
  assign dark_o = (sum_d <= thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q  <= sum_d;
      chan_q <= chan_i;
    end
  end

  assign sum_o  = sum_q;
  assign chan_o = chan_q;

endmodule

// File: design/rcn_ctrl.sv
// Pipeline control: per-stage valid and dark flags with bubble collapsing,
// plus the output valid register. Depends on rcn_pkg.
module rcn_ctrl import rcn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      dark_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output pipe_ctl_t ctl_o
);

  logic [PIPE_DEPTH-1:0] v_q;
  logic [PIPE_DEPTH-1:0] dk_q;
  logic                  ov_q;
  logic [PIPE_DEPTH:0]   free;
  logic [PIPE_DEPTH-1:0] v_in;
  logic [PIPE_DEPTH-1:0] dk_in;

  // A stage may load when it is empty or some stage further down has room,
  // so the pipeline keeps filling while the output is stalled.
  always_comb begin
    free[PIPE_DEPTH] = !ov_q || out_ready_i;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k+1];
    end
  end

  assign v_in  = {v_q[PIPE_DEPTH-2:0], in_valid_i};
  assign dk_in = {dk_q[PIPE_DEPTH-2:0], dark_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (free[k]) begin
          v_q[k] <= v_in[k];
        end
      end
      if (free[PIPE_DEPTH]) begin
        ov_q <= v_q[PIPE_DEPTH-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (free[k]) begin
        dk_q[k] <= dk_in[k];
      end
    end
  end

  assign in_ready_o     = free[0];
  assign out_valid_o    = ov_q;
  assign ctl_o.en       = free[PIPE_DEPTH-1:0];
  assign ctl_o.out_en   = free[PIPE_DEPTH];
  assign ctl_o.out_dark = dk_q[PIPE_DEPTH-1];

endmodule

// File: design/rcn_lane.sv
// One channel lane: numerator stage followed by a pipelined restoring
// divider that yields floor((2*SCALE*c + sum) / (2*sum)). Depends on rcn_pkg.
module rcn_lane import rcn_pkg::*; (
  input  logic                  clk_i,
  input  chan_t                 chan_i,
  input  sum_t                  sum_i,
  input  logic [PIPE_DEPTH-1:1] en_i,
  output chan_t                 quo_o
);

  logic [NUM_W-1:0]     rem_q [DIV_STEPS];
  logic [DEN_W-1:0]     den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic [NUM_W-1:0]     num_d;

  // Adding sum to the doubled numerator and doubling the divisor gives round-half-up.
  assign num_d = NUM_W'(chan_i) * NUM_W'(2 * SCALE) + NUM_W'(sum_i);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rem_q[0] <= num_d;
      den_q[0] <= {sum_i, 1'b0};
      quo_q[0] <= '0;
    end
  end

  // The quotient never exceeds SCALE, so DIV_STEPS bits cover it.
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    logic [TRIAL_W-1:0] trial;
    logic               ge;

    assign trial  = TRIAL_W'(den_q[j-1]) << (DIV_STEPS - j);
    assign ge     = (TRIAL_W'(rem_q[j-1]) >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i[j+1]) begin
        quo_q[j] <= {quo_q[j-1][DIV_STEPS-2:0], ge};
      end
    end

    if (j < DIV_STEPS) begin : g_carry
      logic [NUM_W-1:0] rem_nx;

      assign rem_nx = ge ? (rem_q[j-1] - trial[NUM_W-1:0]) : rem_q[j-1];

      always_ff @(posedge clk_i) begin
        if (en_i[j+1]) begin
          rem_q[j] <= rem_nx;
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS];

endmodule

// File: design/rcn_merge.sv
// Output stage: merges the lane quotients into the result register and
// forces a black pixel when the dark flag is set. Depends on rcn_pkg.
module rcn_merge import rcn_pkg::*; (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  chan_t     quo_i  [LANES],
  output chan_t     norm_o [LANES]
);

  chan_t norm_q [LANES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_en) begin
      for (int l = 0; l < LANES; l++) begin
        norm_q[l] <= ctl_i.out_dark ? '0 : quo_i[l];
      end
    end
  end

  assign norm_o = norm_q;

endmodule

// File: design/rgb_chromaticity_normalizer_unit.sv
// Normalised RGB chromaticity unit. Each pixel of three 8-bit channels
// (RGB or BGR order, the maths is symmetric) is scaled so that every
// channel becomes round(255 * c / (r + g + b)); a pixel whose sum does not
// exceed the dark threshold comes out black.
//
// Channels: the input pixel and the output pixel both use valid/ready, a
// transfer taking place on a clock edge with both high. The threshold is
// loaded through the cfg channel (cfg_ready_o is always high) and should
// only change while no pixel is in flight.
//
// A pixel passes one input register, one numerator stage, eight divider
// stages (one quotient bit each, three lanes side by side) and the output
// register. Throughput is one pixel per cycle while the receiver takes
// results. When the receiver stalls, the result holds in the output
// register and the pipeline keeps accepting pixels until all ten
// stages are full, after which in_ready_o drops.
//
// Reset clears all valid flags and sets the threshold to zero.
// Depends on rcn_pkg, rcn_front, rcn_ctrl, rcn_lane and rcn_merge.
module rgb_chromaticity_normalizer_unit import rcn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SUM_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CH_W-1:0]  first_channel_i,
  input  logic [CH_W-1:0]  second_channel_i,
  input  logic [CH_W-1:0]  third_channel_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CH_W-1:0]  first_norm_o,
  output logic [CH_W-1:0]  second_norm_o,
  output logic [CH_W-1:0]  third_norm_o
);

  chan_t     chan_in [LANES];
  chan_t     chan_s0 [LANES];
  chan_t     quo     [LANES];
  chan_t     norm    [LANES];
  sum_t      sum_s0;
  logic      dark;
  pipe_ctl_t ctl;

  assign cfg_ready_o = 1'b1;

  assign chan_in[0] = first_channel_i;
  assign chan_in[1] = second_channel_i;
  assign chan_in[2] = third_channel_i;

  rcn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .chan_i      (chan_in),
    .load_i      (ctl.en[0]),
    .chan_o      (chan_s0),
    .sum_o       (sum_s0),
    .dark_o      (dark)
  );

  rcn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .dark_i      (dark),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rcn_lane u_lane (
      .clk_i  (clk_i),
      .chan_i (chan_s0[l]),
      .sum_i  (sum_s0),
      .en_i   (ctl.en[PIPE_DEPTH-1:1]),
      .quo_o  (quo[l])
    );
  end

  rcn_merge u_merge (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .quo_i  (quo),
    .norm_o (norm)
  );

  assign first_norm_o  = norm[0];
  assign second_norm_o = norm[1];
  assign third_norm_o  = norm[2];

endmodule

// File: design/rcn_checker.sv
// Port-level checker for the chromaticity unit, bound to the top level.
// Depends on rcn_pkg and rgb_chromaticity_normalizer_unit.
module rcn_checker import rcn_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [SUM_W-1:0] cfg_data_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [CH_W-1:0]  first_channel_i,
  input logic [CH_W-1:0]  second_channel_i,
  input logic [CH_W-1:0]  third_channel_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CH_W-1:0]  first_norm_o,
  input logic [CH_W-1:0]  second_norm_o,
  input logic [CH_W-1:0]  third_norm_o
);

  logic [SUM_W-1:0] norm_sum;

  assign norm_sum = SUM_W'(first_norm_o) + SUM_W'(second_norm_o) + SUM_W'(third_norm_o);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(first_norm_o) && $stable(second_norm_o)
      && $stable(third_norm_o))
    else $error("result changed while stalled");

  // With the output register empty nothing downstream can block the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output is empty");

  // Rounded shares of 255 add up to 254..256, or the pixel is black.
  a_norm_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (norm_sum == '0) || (norm_sum >= SUM_W'(SCALE - 1)
      && norm_sum <= SUM_W'(SCALE + 1)))
    else $error("normalised channels do not sum to full scale");

  // The threshold register always takes a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind rgb_chromaticity_normalizer_unit rcn_checker u_rcn_checker (.*);

// File: dv/rcn_norm_checker.sv
// Checker for the RGB chromaticity normaliser: follows the cfg, pixel-in and
// pixel-out channels, predicts every normalised pixel and compares it.
// Depends on rcn_pkg for the channel and sum types.
`timescale 1ns / 100ps

module rcn_norm_checker import rcn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [SUM_W-1:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [CH_W-1:0]  first_channel_i,
  input  logic [CH_W-1:0]  second_channel_i,
  input  logic [CH_W-1:0]  third_channel_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [CH_W-1:0]  first_norm_o,
  input  logic [CH_W-1:0]  second_norm_o,
  input  logic [CH_W-1:0]  third_norm_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned pixels_o,
  output int unsigned dark_pixels_o,
  output int unsigned thr_writes_o
);

  typedef struct packed {
    chan_t first;
    chan_t second;
    chan_t third;
  } norm_pix_t;

  sum_t      dark_thr;
  norm_pix_t pending_norms[$];

  // Rounded 255*c/total, done as floor((510*c + total) / (2*total)).
  function automatic chan_t scale_chan(chan_t c, int unsigned total);
    return chan_t'((2 * SCALE * c + total) / (2 * total));
  endfunction

  function automatic norm_pix_t predict_norm(sum_t thr, chan_t a, chan_t b, chan_t c);
    int unsigned total;
    norm_pix_t   res;
    total = int'(a) + int'(b) + int'(c);
    res   = '0;
    // A zero sum never exceeds the threshold, so no division by zero here.
    if (total > thr) begin
      res.first  = scale_chan(a, total);
      res.second = scale_chan(b, total);
      res.third  = scale_chan(c, total);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    norm_pix_t want;
    if (!rst_ni) begin
      dark_thr = '0;
      pending_norms.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      pixels_o      = 0;
      dark_pixels_o = 0;
      thr_writes_o  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_norms.size() == 0) begin
          $error("unexpected output transfer: %0d %0d %0d",
                 first_norm_o, second_norm_o, third_norm_o);
          fail_count_o++;
        end else begin
          want = pending_norms.pop_front();
          if (first_norm_o !== want.first) begin
            $error("first_norm: expected %0d, got %0d", want.first, first_norm_o);
            fail_count_o++;
          end
          if (second_norm_o !== want.second) begin
            $error("second_norm: expected %0d, got %0d", want.second, second_norm_o);
            fail_count_o++;
          end
          if (third_norm_o !== want.third) begin
            $error("third_norm: expected %0d, got %0d", want.third, third_norm_o);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        dark_thr = cfg_data_i;
        thr_writes_o++;
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_norm(dark_thr, first_channel_i, second_channel_i, third_channel_i);
        pending_norms.push_back(want);
        pixels_o++;
        // A lit pixel always has one channel of at least 85, so all-zero means dark.
        if (want == '0) dark_pixels_o++;
      end
      pending_o = pending_norms.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the RGB chromaticity normaliser testbench: clock, reset, pixel and
// threshold stimulus, output back-pressure and the verdict.
// Depends on rcn_pkg, rgb_chromaticity_normalizer_unit and rcn_norm_checker.
`timescale 1ns / 100ps

module testbench;
  import rcn_pkg::*;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned PHASES      = 10;

  typedef struct packed {
    chan_t first;
    chan_t second;
    chan_t third;
  } pix_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  sum_t       cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  chan_t      first_channel_i;
  chan_t      second_channel_i;
  chan_t      third_channel_i;
  logic       out_valid_o;
  logic       out_ready_i;
  chan_t      first_norm_o;
  chan_t      second_norm_o;
  chan_t      third_norm_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixels;
  int unsigned dark_pixels;
  int unsigned thr_writes;

  bit tx_steady;
  bit rx_steady;
  bit hold_req;

  rgb_chromaticity_normalizer_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_channel_i  (first_channel_i),
    .second_channel_i (second_channel_i),
    .third_channel_i  (third_channel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_norm_o     (first_norm_o),
    .second_norm_o    (second_norm_o),
    .third_norm_o     (third_norm_o)
  );

  rcn_norm_checker norm_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_channel_i  (first_channel_i),
    .second_channel_i (second_channel_i),
    .third_channel_i  (third_channel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_norm_o     (first_norm_o),
    .second_norm_o    (second_norm_o),
    .third_norm_o     (third_norm_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .pixels_o         (pixels),
    .dark_pixels_o    (dark_pixels),
    .thr_writes_o     (thr_writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #800us;
    $display("testbench: FAIL");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random split of a given channel sum (at most 765) over three channels.
  function automatic pix_t pixel_with_sum(int unsigned total);
    int unsigned lo;
    int unsigned hi;
    int unsigned rest;
    pix_t        p;
    lo = (total > 510) ? total - 510 : 0;
    hi = (total < 255) ? total : 255;
    p.first = chan_t'($urandom_range(hi, lo));
    rest = total - p.first;
    lo = (rest > 255) ? rest - 255 : 0;
    hi = (rest < 255) ? rest : 255;
    p.second = chan_t'($urandom_range(hi, lo));
    p.third  = chan_t'(rest - p.second);
    return p;
  endfunction

  function automatic pix_t random_pixel(sum_t thr);
    int unsigned r;
    int          total;
    pix_t        p;
    r = $urandom_range(0, 99);
    if (r < 55 || (r >= 80 && thr > 765)) begin
      p.first  = chan_t'($urandom);
      p.second = chan_t'($urandom);
      p.third  = chan_t'($urandom);
    end else if (r < 70) begin
      // Tiny channels give small sums and coarse rounding.
      p.first  = chan_t'($urandom_range(0, 7));
      p.second = chan_t'($urandom_range(0, 7));
      p.third  = chan_t'($urandom_range(0, 7));
    end else if (r < 80) begin
      p.first  = $urandom_range(0, 1) ? chan_t'(255) : chan_t'(0);
      p.second = $urandom_range(0, 1) ? chan_t'(255) : chan_t'(0);
      p.third  = $urandom_range(0, 1) ? chan_t'(255) : chan_t'(0);
    end else begin
      // Sum just below, on or just above the threshold.
      total = int'(thr) + int'($urandom_range(0, 2)) - 1;
      if (total < 0) total = 0;
      if (total > 765) total = 765;
      p = pixel_with_sum(total);
    end
    return p;
  endfunction

  task automatic push_pixel(input pix_t p);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    first_channel_i  <= p.first;
    second_channel_i <= p.second;
    third_channel_i  <= p.third;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Valid stays high after a transfer only when another pixel follows at once.
  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    push_pixel(p);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_rgb(input int unsigned a, input int unsigned b, input int unsigned c);
    pix_t p;
    p.first  = chan_t'(a);
    p.second = chan_t'(b);
    p.third  = chan_t'(c);
    send_pixel(p);
  endtask

  task automatic drain_pixels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input sum_t thr);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: runs of ready and stalls, plus a long hold-off on request.
  initial begin : receiver
    int unsigned run;
    int unsigned stall;
    run = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        run = 0;
      end else begin
        if (run == 0) begin
          stall = pick_gap();
          if (stall == 0 || rx_steady) begin
            out_ready_i <= 1'b1;
            run = $urandom_range(1, 24);
          end else begin
            out_ready_i <= 1'b0;
            run = stall;
          end
        end
        run--;
      end
    end
  end

  initial begin : stimulus
    sum_t        thr_plan[PHASES];
    int unsigned phase;
    int unsigned k;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    first_channel_i  = '0;
    second_channel_i = '0;
    third_channel_i  = '0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    hold_req         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pixels: zero sum, saturated channels, exact halves and
    // sums on either side of the threshold.
    write_threshold(sum_t'(0));
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(1, 0, 0);
    send_rgb(1, 1, 0);
    send_rgb(0, 1, 1);
    send_rgb(1, 1, 1);
    send_rgb(85, 85, 85);
    send_rgb(1, 2, 3);
    send_rgb(170, 85, 0);
    send_rgb(128, 127, 1);
    drain_pixels();
    write_threshold(sum_t'(300));
    send_rgb(100, 100, 100);
    send_rgb(101, 100, 100);
    send_rgb(255, 45, 0);
    send_rgb(255, 46, 0);
    drain_pixels();
    write_threshold(sum_t'(764));
    send_rgb(255, 255, 254);
    send_rgb(255, 255, 255);
    drain_pixels();
    write_threshold(sum_t'(765));
    send_rgb(255, 255, 255);
    drain_pixels();
    write_threshold(sum_t'(1023));
    send_rgb(255, 255, 255);
    send_rgb(0, 0, 1);
    drain_pixels();

    thr_plan[0] = sum_t'(0);
    thr_plan[1] = sum_t'(1);
    thr_plan[2] = sum_t'(255);
    thr_plan[3] = sum_t'(382);
    thr_plan[4] = sum_t'(500);
    thr_plan[5] = sum_t'(764);
    thr_plan[6] = sum_t'(765);
    thr_plan[7] = sum_t'(1023);
    thr_plan[8] = sum_t'($urandom_range(0, 765));
    thr_plan[9] = sum_t'($urandom_range(0, 1023));

    for (phase = 0; phase < PHASES; phase++) begin
      tx_steady = (phase % 3 == 1);
      rx_steady = (phase % 4 == 2);
      write_threshold(thr_plan[phase]);
      if (phase == 3) begin
        // The receiver holds off while pixels keep coming, so the pipeline fills.
        hold_req = 1'b1;
        for (k = 0; k < 30; k++) push_pixel(random_pixel(thr_plan[phase]));
      end
      for (k = 0; k < 42; k++) begin
        send_pixel(random_pixel(thr_plan[phase]));
        // Sender pauses mid-phase until the pipeline is empty.
        if (phase == 6 && k == 20) drain_pixels();
      end
      drain_pixels();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d pixels over %0d threshold writes, %0d of them dark.",
             pixels, thr_writes, dark_pixels);
    $display("Mismatches or stray transfers: %0d, results outstanding: %0d.",
             fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
